### rtl/core/lrs_pkg.sv
// ----------------------------------------------------------------------------
// lrs_pkg
// Types and codes shared by the link retry supervisor modules.
// ----------------------------------------------------------------------------
package lrs_pkg;

  localparam int CTX_COUNT   = 32;
  localparam int CTX_IDX_W   = $clog2(CTX_COUNT);
  localparam int FIELD_KEY_W = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [3:0] MAX_RETRIES_RST = 4'd4;

  // command codes on the input channel
  localparam logic [1:0] CMD_REGISTER = 2'd0;
  localparam logic [1:0] CMD_EVENT    = 2'd1;
  localparam logic [1:0] CMD_LOOKUP   = 2'd2;
  localparam logic [1:0] CMD_QUERY    = 2'd3;

  // link states
  localparam logic [2:0] LS_IDLE  = 3'd0;
  localparam logic [2:0] LS_CONN  = 3'd1;
  localparam logic [2:0] LS_READY = 3'd2;
  localparam logic [2:0] LS_TF    = 3'd3;
  localparam logic [2:0] LS_SHUT  = 3'd4;

  // context phases
  localparam logic [1:0] PH_FREE = 2'd0;
  localparam logic [1:0] PH_INIT = 2'd1;
  localparam logic [1:0] PH_EST  = 2'd2;

  // result event codes
  localparam logic [3:0] EV_NONE     = 4'd0;
  localparam logic [3:0] EV_UP       = 4'd1;
  localparam logic [3:0] EV_REGFAIL  = 4'd2;
  localparam logic [3:0] EV_FULL     = 4'd3;
  localparam logic [3:0] EV_TEMPDOWN = 4'd4;
  localparam logic [3:0] EV_RECOVER  = 4'd5;
  localparam logic [3:0] EV_DOWN     = 4'd6;
  localparam logic [3:0] EV_BUSY     = 4'd7;
  localparam logic [3:0] EV_HIT      = 4'd8;
  localparam logic [3:0] EV_MISS     = 4'd9;

  typedef struct packed {
    logic [1:0]             command;
    logic [4:0]             channel;
    logic [FIELD_KEY_W-1:0] node_key;
    logic [2:0]             link_state;
    logic [4:0]             slot_index;
  } in_item_t;

  typedef struct packed {
    logic [3:0]             event_res;
    logic [4:0]             slot;
    logic [FIELD_KEY_W-1:0] result_key;
    logic                   alive;
    logic [5:0]             alive_count;
  } out_item_t;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_REG  = 3'd0,
    OP_EVT  = 3'd1,
    OP_LOOK = 3'd2,
    OP_QRY  = 3'd3,
    OP_NOP  = 3'd4
  } op_kind_t;

  typedef struct packed {
    op_kind_t               kind;
    logic [CTX_IDX_W-1:0]   channel;
    logic [FIELD_KEY_W-1:0] node_key;
    logic [2:0]             link_state;
    logic [4:0]             slot_index;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### rtl/core/lrs_front.sv
// ----------------------------------------------------------------------------
// lrs_front
// Accepts input transfers, classifies the command and masks the key.
// ----------------------------------------------------------------------------
module lrs_front #(
  parameter int KEY_BITS = 32
) (
  input  logic             in_valid,
  output logic             in_stall,
  input  lrs_pkg::in_item_t in_item,
  input  lrs_pkg::q_stat_t q_stat,
  output logic             q_push,
  output lrs_pkg::op_t     q_op
);
  import lrs_pkg::*;

  localparam int KW = (KEY_BITS < FIELD_KEY_W) ? KEY_BITS : FIELD_KEY_W;

  logic [FIELD_KEY_W-1:0] key_mask;

  assign key_mask = FIELD_KEY_W'({KW{1'b1}});
  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  always_comb begin
    q_op.channel    = in_item.channel;
    q_op.node_key   = in_item.node_key & key_mask;
    q_op.link_state = in_item.link_state;
    q_op.slot_index = in_item.slot_index;
    case (in_item.command)
      CMD_REGISTER: q_op.kind = OP_REG;
      // an unknown link state is a no-op
      CMD_EVENT:    q_op.kind = (in_item.link_state > LS_SHUT) ? OP_NOP : OP_EVT;
      CMD_LOOKUP:   q_op.kind = OP_LOOK;
      CMD_QUERY:    q_op.kind = OP_QRY;
      default:      q_op.kind = OP_NOP;
    endcase
  end

endmodule

### rtl/core/lrs_queue.sv
// ----------------------------------------------------------------------------
// lrs_queue
// Short FIFO of classified operations between front and back.
// ----------------------------------------------------------------------------
module lrs_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lrs_pkg::op_t     push_op,
  input  logic             pop,
  output lrs_pkg::op_t     head_op,
  output lrs_pkg::q_stat_t stat
);
  import lrs_pkg::*;

  op_t               mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign stat.full  = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head_op    = mem_r[rd_ptr_r];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

### rtl/core/lrs_back.sv
// ----------------------------------------------------------------------------
// lrs_back
// Executes operations against the context and slot tables; owns the
// retry limit register and the result register.
// ----------------------------------------------------------------------------
module lrs_back #(
  parameter int SLOTS    = 32,
  parameter int KEY_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [3:0]        cfg_wr_data,
  input  lrs_pkg::q_stat_t  q_stat,
  input  lrs_pkg::op_t      q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output lrs_pkg::out_item_t out_item
);
  import lrs_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int KW = (KEY_BITS < FIELD_KEY_W) ? KEY_BITS : FIELD_KEY_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } bk_state_t;

  bk_state_t   st_r, st_nxt;
  op_t         op_r;
  logic [SLOTS-1:0] match_r, match_nxt;
  logic [SLOTS-1:0] slot_free_r, slot_alive_r;
  logic        free_any_r, free_any_nxt;
  logic [SW-1:0] free_idx_r, free_idx_nxt;
  logic [KW-1:0] slot_key_r [SLOTS];

  logic [1:0]    ctx_phase_r [CTX_COUNT];
  logic [2:0]    ctx_prev_r  [CTX_COUNT];
  logic [3:0]    ctx_retry_r [CTX_COUNT];
  logic [KW-1:0] ctx_key_r   [CTX_COUNT];
  logic [SW-1:0] ctx_slot_r  [CTX_COUNT];

  logic [3:0]    max_retries_r;
  logic [CW-1:0] alive_cnt_r, alive_cnt_nxt;
  logic          out_valid_r;
  out_item_t     out_item_r, out_item_nxt;

  // current context view
  logic [1:0]    cur_ph;
  logic [2:0]    cur_prev;
  logic [3:0]    cur_retry;
  logic [KW-1:0] cur_key;
  logic [SW-1:0] cur_slot;
  logic          retry_ok;

  // table write controls
  logic [1:0]    ph_nxt;
  logic [2:0]    prev_nxt;
  logic [3:0]    retry_nxt;
  logic          ctx_key_wr, ctx_slot_wr;
  logic          slot_wr, slot_key_wr;
  logic [SW-1:0] sidx;
  logic          free_val, alive_val, old_alive;
  logic          keep;

  logic          hit_any;
  logic [SW-1:0] hit_idx;
  logic [8:0]    q_wide;
  logic [SW-1:0] q_idx;
  logic          q_in_range;
  logic [8:0]    sidx_wide, hit_wide, cnt_wide;
  logic          out_free, exec;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign q_pop     = (st_r == ST_IDLE) && !q_stat.empty && out_free;
  assign exec      = (st_r == ST_EXEC);

  // search cycle: per-slot key compare and lowest free slot
  always_comb begin
    free_any_nxt = 1'b0;
    free_idx_nxt = '0;
    for (int s = 0; s < SLOTS; s++) begin
      match_nxt[s] = !slot_free_r[s] && (slot_key_r[s] == q_head.node_key[KW-1:0]);
    end
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (slot_free_r[s]) begin
        free_any_nxt = 1'b1;
        free_idx_nxt = SW'(s);
      end
    end
  end

  always_comb begin
    hit_any = |match_r;
    hit_idx = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (match_r[s]) begin
        hit_idx = SW'(s);
      end
    end
  end

  assign cur_ph    = ctx_phase_r[op_r.channel];
  assign cur_prev  = ctx_prev_r[op_r.channel];
  assign cur_retry = ctx_retry_r[op_r.channel];
  assign cur_key   = ctx_key_r[op_r.channel];
  assign cur_slot  = ctx_slot_r[op_r.channel];
  assign retry_ok  = (cur_retry < max_retries_r);

  assign q_wide     = 9'(op_r.slot_index);
  assign q_idx      = q_wide[SW-1:0];
  assign q_in_range = (q_wide < 9'(SLOTS));
  assign hit_wide   = 9'(hit_idx);

  // execute cycle
  always_comb begin
    ph_nxt      = cur_ph;
    prev_nxt    = cur_prev;
    retry_nxt   = cur_retry;
    ctx_key_wr  = 1'b0;
    ctx_slot_wr = 1'b0;
    slot_wr     = 1'b0;
    slot_key_wr = 1'b0;
    sidx        = cur_slot;
    sidx_wide   = '0;
    free_val    = 1'b0;
    alive_val   = 1'b0;
    keep        = 1'b1;
    out_item_nxt = '0;
    out_item_nxt.event_res = EV_NONE;

    case (op_r.kind)
      OP_REG: begin
        if (cur_ph != PH_FREE) begin
          out_item_nxt.event_res  = EV_BUSY;
          out_item_nxt.result_key = FIELD_KEY_W'(cur_key);
        end else begin
          ph_nxt     = PH_INIT;
          prev_nxt   = LS_IDLE;
          retry_nxt  = 4'd0;
          ctx_key_wr = 1'b1;
          out_item_nxt.result_key = op_r.node_key;
        end
      end
      OP_EVT: begin
        if (cur_ph == PH_INIT) begin
          out_item_nxt.result_key = FIELD_KEY_W'(cur_key);
          if (op_r.link_state == LS_READY) begin
            if (free_any_r) begin
              sidx        = free_idx_r;
              slot_wr     = 1'b1;
              free_val    = 1'b0;
              alive_val   = 1'b1;
              slot_key_wr = 1'b1;
              ctx_slot_wr = 1'b1;
              retry_nxt   = 4'd0;
              ph_nxt      = PH_EST;
              prev_nxt    = LS_READY;
              out_item_nxt.event_res = EV_UP;
              out_item_nxt.alive     = 1'b1;
              sidx_wide              = 9'(free_idx_r);
              out_item_nxt.slot      = sidx_wide[4:0];
            end else begin
              ph_nxt = PH_FREE;
              out_item_nxt.event_res = EV_FULL;
            end
          end else begin
            case (op_r.link_state)
              LS_TF: keep = retry_ok;
              LS_CONN: keep = (cur_prev == LS_CONN) ? retry_ok : 1'b1;
              default: keep = 1'b0;
            endcase
            if (keep && (op_r.link_state == LS_TF ||
                         (op_r.link_state == LS_CONN && cur_prev == LS_CONN))) begin
              retry_nxt = cur_retry + 4'd1;
            end
            if (keep) begin
              prev_nxt = op_r.link_state;
            end else begin
              ph_nxt = PH_FREE;
              out_item_nxt.event_res = EV_REGFAIL;
            end
          end
        end else if (cur_ph != PH_FREE) begin
          // established rules
          slot_wr   = 1'b1;
          free_val  = slot_free_r[cur_slot];
          alive_val = slot_alive_r[cur_slot];
          case (op_r.link_state)
            LS_CONN: begin
              if (cur_prev == LS_CONN) begin
                keep = retry_ok;
                if (retry_ok) retry_nxt = cur_retry + 4'd1;
              end
            end
            LS_IDLE: begin
              alive_val = 1'b0;
              out_item_nxt.event_res = EV_TEMPDOWN;
            end
            LS_READY: begin
              if (cur_prev != LS_READY) begin
                retry_nxt = 4'd0;
                alive_val = 1'b1;
                out_item_nxt.event_res = EV_RECOVER;
              end
            end
            LS_TF: begin
              if (cur_prev == LS_READY) begin
                alive_val = 1'b0;
                out_item_nxt.event_res = EV_TEMPDOWN;
              end else if (cur_prev == LS_CONN || cur_prev == LS_TF) begin
                keep = retry_ok;
                if (retry_ok) retry_nxt = cur_retry + 4'd1;
              end else begin
                keep = 1'b0;
              end
            end
            default: keep = 1'b0;
          endcase
          sidx_wide = 9'(cur_slot);
          out_item_nxt.slot       = sidx_wide[4:0];
          out_item_nxt.result_key = FIELD_KEY_W'(cur_key);
          if (keep) begin
            prev_nxt = op_r.link_state;
            out_item_nxt.alive = alive_val;
          end else begin
            free_val  = 1'b1;
            alive_val = 1'b0;
            ph_nxt    = PH_FREE;
            out_item_nxt.event_res = EV_DOWN;
            out_item_nxt.alive     = 1'b0;
          end
        end
      end
      OP_LOOK: begin
        out_item_nxt.result_key = op_r.node_key;
        if (hit_any) begin
          out_item_nxt.event_res = EV_HIT;
          out_item_nxt.slot      = hit_wide[4:0];
          out_item_nxt.alive     = slot_alive_r[hit_idx];
        end else begin
          out_item_nxt.event_res = EV_MISS;
        end
      end
      OP_QRY: begin
        out_item_nxt.slot = op_r.slot_index;
        if (q_in_range && !slot_free_r[q_idx]) begin
          out_item_nxt.result_key = FIELD_KEY_W'(slot_key_r[q_idx]);
          out_item_nxt.alive      = slot_alive_r[q_idx];
        end
      end
      default: begin
      end
    endcase

    old_alive     = slot_alive_r[sidx];
    alive_cnt_nxt = alive_cnt_r;
    if (slot_wr && alive_val && !old_alive) begin
      alive_cnt_nxt = alive_cnt_r + 1'b1;
    end else if (slot_wr && !alive_val && old_alive) begin
      alive_cnt_nxt = alive_cnt_r - 1'b1;
    end
    cnt_wide = 9'(alive_cnt_nxt);
    out_item_nxt.alive_count = (cnt_wide > 9'd63) ? 6'd63 : cnt_wide[5:0];
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (q_pop) st_nxt = ST_EXEC;
      ST_EXEC: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= ST_IDLE;
      out_valid_r   <= 1'b0;
      max_retries_r <= MAX_RETRIES_RST;
      slot_free_r   <= '1;
      slot_alive_r  <= '0;
      alive_cnt_r   <= '0;
      for (int c = 0; c < CTX_COUNT; c++) begin
        ctx_phase_r[c] <= PH_FREE;
        ctx_prev_r[c]  <= LS_IDLE;
        ctx_retry_r[c] <= 4'd0;
      end
    end else begin
      st_r <= st_nxt;
      if (cfg_wr_en) begin
        max_retries_r <= cfg_wr_data;
      end
      if (exec) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (exec) begin
        ctx_phase_r[op_r.channel] <= ph_nxt;
        ctx_prev_r[op_r.channel]  <= prev_nxt;
        ctx_retry_r[op_r.channel] <= retry_nxt;
        alive_cnt_r               <= alive_cnt_nxt;
        if (slot_wr) begin
          slot_free_r[sidx]  <= free_val;
          slot_alive_r[sidx] <= alive_val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r       <= q_head;
      match_r    <= match_nxt;
      free_any_r <= free_any_nxt;
      free_idx_r <= free_idx_nxt;
    end
    if (exec) begin
      out_item_r <= out_item_nxt;
      if (ctx_key_wr) begin
        ctx_key_r[op_r.channel] <= op_r.node_key[KW-1:0];
      end
      if (ctx_slot_wr) begin
        ctx_slot_r[op_r.channel] <= sidx;
      end
      if (slot_key_wr) begin
        slot_key_r[sidx] <= cur_key;
      end
    end
  end

endmodule

### rtl/core/link_retry_supervisor_slot_table.sv
// ----------------------------------------------------------------------------
// link_retry_supervisor_slot_table
// Link context supervisor with retry limits and a slot table.
// ----------------------------------------------------------------------------
//  channel | ports                         | payload
//  --------+-------------------------------+------------------------------
//  input   | in_valid / in_stall           | in_item  (lrs_pkg::in_item_t)
//  result  | out_valid / out_stall         | out_item (lrs_pkg::out_item_t)
//  config  | cfg_wr_en                     | cfg_wr_data (max_retries)
//
//  In the back unit each item pops the queue and runs the key compare and
//  free-slot search, then executes and loads the result before the next pop.
//  The front takes a transfer whenever the 2-entry queue has room.
//  Synchronous reset frees all contexts and slots at once; no clearing pass.
//  A stalled result holds the back unit; the queue still fills behind it.
module link_retry_supervisor_slot_table #(
  parameter int SLOTS    = 32,
  parameter int KEY_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [3:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  lrs_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output lrs_pkg::out_item_t out_item
);
  import lrs_pkg::*;

  q_stat_t q_stat;
  logic    q_push, q_pop;
  op_t     q_op, q_head;

  lrs_front #(
    .KEY_BITS (KEY_BITS)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_op     (q_op)
  );

  lrs_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_op),
    .pop     (q_pop),
    .head_op (q_head),
    .stat    (q_stat)
  );

  lrs_back #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_stat      (q_stat),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule
